>>> rtl/core/gcode_line_checker_queue_core_assert.svh
// Assertion macros shared by the line checker queue checker.
`ifndef GCODE_LINE_CHECKER_QUEUE_CORE_ASSERT_SVH
`define GCODE_LINE_CHECKER_QUEUE_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk and quiet during rst.
`define GLCQ_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("glcq assertion failed");

// Next-cycle implication, sampled on clk and quiet during rst.
`define GLCQ_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("glcq assertion failed");

`endif

>>> rtl/core/glcq_pkg.sv
// Types, codes and character constants of the line checker queue.
package glcq_pkg;

  localparam int QUEUE_SLOTS_DEF = 4;
  localparam int LINE_MAX_DEF    = 96;
  localparam int OUT_DEPTH       = 3;

  localparam logic [7:0] CH_HT     = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_N      = 8'h4E;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  localparam logic [31:0] TXT_M110 = 32'h4D31_3130;
  localparam logic [31:0] TXT_M108 = 32'h4D31_3038;
  localparam logic [31:0] TXT_M112 = 32'h4D31_3132;
  localparam logic [31:0] TXT_M410 = 32'h4D34_3130;

  localparam logic [31:0] MAG_SAT  = 32'h8000_0000;

  typedef enum logic [1:0] {
    REQ_BYTE    = 2'd0,
    REQ_RELEASE = 2'd1,
    REQ_READ    = 2'd2
  } req_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_BAD_NUM = 3'd1,
    ST_CHK_BAD = 3'd2,
    ST_NO_CHK  = 3'd3,
    ST_NO_NUM  = 3'd4,
    ST_FULL    = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    EM_NONE = 2'd0,
    EM_M108 = 2'd1,
    EM_M112 = 2'd2,
    EM_M410 = 2'd3
  } emerg_t;

  typedef enum logic {
    KIND_LINE = 1'b0,
    KIND_READ = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_SKIP,
    PH_DIGIT,
    PH_DONE
  } phase_t;

  typedef struct packed {
    logic        kind;
    logic [2:0]  status;
    logic        resend;
    logic [30:0] resend_line;
    logic [6:0]  len;
    logic [3:0]  slot;
    logic [1:0]  emerg;
    logic [7:0]  rchar;
    logic [4:0]  qcount;
  } res_t;

endpackage

>>> rtl/core/gcode_line_checker_queue_core.sv
// Serial line checker with a ring of command slots held in one synchronous RAM.
// Back-to-back words are accepted at one per cycle while the output queue has room.
// Each result is registered in stage one, beside the RAM read of a character,
// and then written into the three-entry output queue.
// Synchronous reset empties the ring and the output queue; no clearing pass is needed.
module gcode_line_checker_queue_core import glcq_pkg::*; #(
  parameter int QUEUE_SLOTS = QUEUE_SLOTS_DEF,
  parameter int LINE_MAX    = LINE_MAX_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  req_type,
  input  logic [7:0]  data_byte,
  input  logic [6:0]  char_offset,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        result_kind,
  output logic [2:0]  status,
  output logic        resend_request,
  output logic [30:0] resend_line,
  output logic [6:0]  line_length,
  output logic [3:0]  slot_written,
  output logic [1:0]  emergency_code,
  output logic [7:0]  read_char,
  output logic [4:0]  queue_count
);

  localparam int OW   = $clog2(LINE_MAX);
  localparam int PHYS = QUEUE_SLOTS + 1;
  localparam int PW   = $clog2(PHYS);
  localparam int QW   = $clog2(QUEUE_SLOTS);
  localparam int HW   = $clog2(QUEUE_SLOTS + 1);
  localparam int AW   = PW + OW;
  localparam int CW   = (OW > 7) ? OW : 7;
  localparam logic [OW-1:0] LEN_CAP = OW'(LINE_MAX - 1);

  // Line assembly state.
  logic [OW-1:0]     line_len;
  logic              comment_mode;
  logic              escape_pending;
  logic              nonspace_seen;
  logic              first_semi;
  logic [2:0]        rel_count;
  logic [31:0]       last4;
  logic              m110_seen;
  logic [7:0]        xor_acc;
  logic signed [31:0] last_good;

  // Ring state: one more buffer than slots, so the line being built never
  // lands in a held command.
  logic [PW-1:0]     wphys, rphys;
  logic [QW-1:0]     write_slot;
  logic [HW-1:0]     held;
  logic [OW-1:0]     slot_len [PHYS];
  logic [7:0]        ring_mem [2**AW];
  logic [7:0]        mem_q;

  // Pipeline and output queue.
  logic              p1_valid;
  logic              p1_rd_ok;
  res_t              p1_res;
  res_t              outq [OUT_DEPTH];
  logic [1:0]        q_head, q_tail, q_cnt;

  logic              acc, is_byte, is_release, is_read, is_eol, room;
  logic              store, finish, esc_set, com_set;
  logic              trig_n, trig_m, trig_s;
  logic              n_started, m_started, s_started;
  logic signed [31:0] n_raw, m_raw, s_val, n_val;
  logic [32:0]       lp1, lpn;
  logic              n_match, chk_match, good, take;
  status_t           status_f;
  emerg_t            emerg_f;
  logic signed [31:0] last_next;
  logic [30:0]       resend_val;
  logic [HW-1:0]     held_next;
  logic              rd_ok;
  logic [AW-1:0]     raddr;
  logic              push, pop;
  res_t              q_in;

  always_comb begin
    acc        = in_valid && in_ready;
    is_byte    = acc && (req_type == REQ_BYTE);
    is_release = acc && (req_type == REQ_RELEASE);
    is_read    = acc && (req_type == REQ_READ);
    is_eol     = (data_byte == CH_LF) || (data_byte == CH_CR);
    room       = (line_len < LEN_CAP);
    store      = 1'b0;
    finish     = 1'b0;
    esc_set    = 1'b0;
    com_set    = 1'b0;
    if (is_byte) begin
      if (escape_pending) begin
        store = !comment_mode && room;
      end else if (is_eol) begin
        finish = (line_len != '0);
      end else if (room) begin
        if (data_byte == CH_BSLASH) begin
          esc_set = 1'b1;
        end else if (data_byte == CH_SEMI) begin
          com_set = 1'b1;
        end else begin
          store = !comment_mode;
        end
      end
    end
    trig_n = !nonspace_seen && (data_byte == CH_N);
    trig_m = nonspace_seen && (rel_count >= 3'd4) && (data_byte == CH_N);
    trig_s = (data_byte == CH_STAR);
  end

  // Number after an 'N' that is the first non-blank character.
  glcq_dec_parser u_num_n (
    .clk(clk), .rst(rst), .clear(finish), .stored(store), .trig(trig_n),
    .ch(data_byte), .started(n_started), .value(n_raw)
  );

  // Number after an 'N' at least four places later, used by M110.
  glcq_dec_parser u_num_m (
    .clk(clk), .rst(rst), .clear(finish), .stored(store), .trig(trig_m),
    .ch(data_byte), .started(m_started), .value(m_raw)
  );

  // Checksum after the first '*'.
  glcq_dec_parser u_num_s (
    .clk(clk), .rst(rst), .clear(finish), .stored(store), .trig(trig_s),
    .ch(data_byte), .started(s_started), .value(s_val)
  );

  // Line-end checks, all from state built up while the line came in.
  always_comb begin
    n_val     = (m110_seen && m_started) ? m_raw : n_raw;
    lp1       = {last_good[31], last_good} + 33'd1;
    n_match   = ({n_val[31], n_val} == lp1);
    chk_match = (s_val == {24'd0, xor_acc});
    status_f  = ST_OK;
    if (n_started) begin
      if (!n_match && !m110_seen) begin
        status_f = ST_BAD_NUM;
      end else if (!s_started) begin
        status_f = ST_NO_CHK;
      end else if (!chk_match) begin
        status_f = ST_CHK_BAD;
      end
    end else if (s_started) begin
      status_f = ST_NO_NUM;
    end
    good    = (status_f == ST_OK);
    emerg_f = EM_NONE;
    if (good && (rel_count == 3'd4)) begin
      if (last4 == TXT_M108) begin
        emerg_f = EM_M108;
      end else if (last4 == TXT_M112) begin
        emerg_f = EM_M112;
      end else if (last4 == TXT_M410) begin
        emerg_f = EM_M410;
      end
    end
    take = finish && good && !first_semi && (held < HW'(QUEUE_SLOTS));
    if (good && !first_semi && !(held < HW'(QUEUE_SLOTS))) begin
      status_f = ST_FULL;
    end
    last_next  = (finish && n_started && good) ? n_val : last_good;
    lpn        = {last_next[31], last_next} + 33'd1;
    resend_val = lpn[32] ? 31'd0 : (lpn[31] ? 31'h7FFF_FFFF : lpn[30:0]);
    held_next  = held;
    if (take) begin
      held_next = held + HW'(1);
    end else if (is_release && (held != '0)) begin
      held_next = held - HW'(1);
    end
    rd_ok = (held != '0) && (CW'(char_offset) < CW'(slot_len[rphys]));
    raddr = {rphys, OW'(char_offset)};
  end

  always_ff @(posedge clk) begin
    if (store) begin
      ring_mem[{wphys, line_len}] <= data_byte;
    end
    mem_q <= ring_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (take) begin
      slot_len[wphys] <= line_len;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_len       <= '0;
      comment_mode   <= 1'b0;
      escape_pending <= 1'b0;
      nonspace_seen  <= 1'b0;
      first_semi     <= 1'b0;
      rel_count      <= '0;
      last4          <= '0;
      m110_seen      <= 1'b0;
      xor_acc        <= '0;
      last_good      <= '0;
      wphys          <= '0;
      rphys          <= '0;
      write_slot     <= '0;
      held           <= '0;
    end else begin
      if (is_byte) begin
        if (escape_pending) begin
          escape_pending <= 1'b0;
        end else if (is_eol) begin
          comment_mode <= 1'b0;
        end
        if (esc_set) begin
          escape_pending <= 1'b1;
        end
        if (com_set) begin
          comment_mode <= 1'b1;
        end
      end
      if (store) begin
        line_len <= line_len + OW'(1);
        last4    <= {last4[23:0], data_byte};
        if (line_len == '0) begin
          first_semi <= (data_byte == CH_SEMI);
        end
        if ({last4[23:0], data_byte} == TXT_M110) begin
          m110_seen <= 1'b1;
        end
        if (nonspace_seen) begin
          if (rel_count < 3'd5) begin
            rel_count <= rel_count + 3'd1;
          end
        end else if (data_byte != CH_SPACE) begin
          nonspace_seen <= 1'b1;
          rel_count     <= 3'd1;
        end
        // Leading blanks and everything from the '*' on stay out of the checksum.
        if (!s_started && (data_byte != CH_STAR) &&
            (nonspace_seen || (data_byte != CH_SPACE))) begin
          xor_acc <= xor_acc ^ data_byte;
        end
      end
      if (finish) begin
        line_len      <= '0;
        nonspace_seen <= 1'b0;
        first_semi    <= 1'b0;
        rel_count     <= '0;
        last4         <= '0;
        m110_seen     <= 1'b0;
        xor_acc       <= '0;
      end
      last_good <= last_next;
      held      <= held_next;
      if (take) begin
        wphys      <= (wphys == PW'(PHYS - 1)) ? '0 : wphys + PW'(1);
        write_slot <= (write_slot == QW'(QUEUE_SLOTS - 1)) ? '0 : write_slot + QW'(1);
      end
      if (is_release && (held != '0)) begin
        rphys <= (rphys == PW'(PHYS - 1)) ? '0 : rphys + PW'(1);
      end
    end
  end

  // Stage one: the result waits here for the RAM read data.
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else begin
      p1_valid <= finish || is_read;
    end
  end

  always_ff @(posedge clk) begin
    p1_rd_ok           <= is_read && rd_ok;
    p1_res.kind        <= is_read ? KIND_READ : KIND_LINE;
    p1_res.status      <= is_read ? ST_OK : status_f;
    p1_res.resend      <= !is_read && ((status_f == ST_BAD_NUM) ||
                          (status_f == ST_CHK_BAD) || (status_f == ST_NO_CHK));
    p1_res.resend_line <= resend_val;
    p1_res.len         <= is_read ? 7'd0 : 7'(line_len);
    p1_res.slot        <= (is_read || !take) ? 4'd0 : 4'(write_slot);
    p1_res.emerg       <= is_read ? EM_NONE : emerg_f;
    p1_res.rchar       <= 8'd0;
    p1_res.qcount      <= 5'(held_next);
  end

  always_comb begin
    q_in       = p1_res;
    q_in.rchar = p1_rd_ok ? mem_q : 8'd0;
    push       = p1_valid;
    pop        = out_valid && out_ready;
    in_ready   = (3'(q_cnt) + 3'(p1_valid)) < 3'(OUT_DEPTH);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      outq[q_tail] <= q_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_head <= '0;
      q_tail <= '0;
      q_cnt  <= '0;
    end else begin
      if (push) begin
        q_tail <= (q_tail == 2'(OUT_DEPTH - 1)) ? 2'd0 : q_tail + 2'd1;
      end
      if (pop) begin
        q_head <= (q_head == 2'(OUT_DEPTH - 1)) ? 2'd0 : q_head + 2'd1;
      end
      if (push && !pop) begin
        q_cnt <= q_cnt + 2'd1;
      end else if (pop && !push) begin
        q_cnt <= q_cnt - 2'd1;
      end
    end
  end

  always_comb begin
    out_valid      = (q_cnt != 2'd0);
    result_kind    = outq[q_head].kind;
    status         = outq[q_head].status;
    resend_request = outq[q_head].resend;
    resend_line    = outq[q_head].resend_line;
    line_length    = outq[q_head].len;
    slot_written   = outq[q_head].slot;
    emergency_code = outq[q_head].emerg;
    read_char      = outq[q_head].rchar;
    queue_count    = outq[q_head].qcount;
  end

endmodule

>>> rtl/core/glcq_dec_parser.sv
// Incremental decimal parser that follows a trigger character in the stored line.
module glcq_dec_parser import glcq_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               clear,
  input  logic               stored,
  input  logic               trig,
  input  logic [7:0]         ch,
  output logic               started,
  output logic signed [31:0] value
);

  phase_t      phase, phase_next;
  logic        neg, neg_next;
  logic [31:0] mag, mag_next;
  logic        is_digit, is_blank, is_sign;
  logic [3:0]  digit;
  logic [35:0] acc;
  logic [31:0] mag_acc;

  always_comb begin
    is_digit = (ch >= CH_0) && (ch <= CH_9);
    is_blank = (ch == CH_SPACE) || ((ch >= CH_HT) && (ch <= CH_CR));
    is_sign  = (ch == CH_PLUS) || (ch == CH_MINUS);
    digit    = 4'(ch - CH_0);
    acc      = ({4'd0, mag} << 3) + ({4'd0, mag} << 1) + 36'(digit);
    mag_acc  = (acc > 36'(MAG_SAT)) ? MAG_SAT : acc[31:0];
  end

  always_comb begin
    phase_next = phase;
    neg_next   = neg;
    mag_next   = mag;
    if (clear) begin
      phase_next = PH_IDLE;
      neg_next   = 1'b0;
      mag_next   = '0;
    end else if (stored) begin
      unique case (phase)
        PH_IDLE: begin
          if (trig) begin
            phase_next = PH_SKIP;
            neg_next   = 1'b0;
            mag_next   = '0;
          end
        end
        PH_SKIP: begin
          if (is_blank) begin
            phase_next = PH_SKIP;
          end else if (is_sign) begin
            phase_next = PH_DIGIT;
            neg_next   = (ch == CH_MINUS);
          end else if (is_digit) begin
            phase_next = PH_DIGIT;
            mag_next   = mag_acc;
          end else begin
            phase_next = PH_DONE;
          end
        end
        PH_DIGIT: begin
          if (is_digit) begin
            mag_next = mag_acc;
          end else begin
            phase_next = PH_DONE;
          end
        end
        PH_DONE: phase_next = PH_DONE;
        default: phase_next = PH_IDLE;
      endcase
    end
  end

  // The magnitude saturates at 2^31, so a positive result clamps one below it.
  always_comb begin
    started = (phase != PH_IDLE);
    if (neg) begin
      value = $signed(32'(33'd0 - {1'b0, mag}));
    end else if (mag[31]) begin
      value = 32'sh7FFF_FFFF;
    end else begin
      value = $signed(mag);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      neg   <= 1'b0;
      mag   <= '0;
    end else begin
      phase <= phase_next;
      neg   <= neg_next;
      mag   <= mag_next;
    end
  end

endmodule

>>> rtl/core/glcq_checker.sv
// Port-level checker for the line checker queue, bound to the top level.
`include "gcode_line_checker_queue_core_assert.svh"

module glcq_checker import glcq_pkg::*; #(
  parameter int QUEUE_SLOTS = QUEUE_SLOTS_DEF
) (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic        result_kind,
  input logic [2:0]  status,
  input logic        resend_request,
  input logic [6:0]  line_length,
  input logic [3:0]  slot_written,
  input logic [1:0]  emergency_code,
  input logic [7:0]  read_char,
  input logic [4:0]  queue_count
);

  `GLCQ_ASSERT_IMP(a_read_clean, out_valid && (result_kind == KIND_READ), (status == ST_OK) && (line_length == 7'd0) && (slot_written == 4'd0) && (emergency_code == EM_NONE))
  `GLCQ_ASSERT_IMP(a_resend_code, out_valid, resend_request == ((status == ST_BAD_NUM) || (status == ST_CHK_BAD) || (status == ST_NO_CHK)))
  `GLCQ_ASSERT_IMP(a_emerg_good, out_valid && (emergency_code != EM_NONE), (result_kind == KIND_LINE) && ((status == ST_OK) || (status == ST_FULL)) && (read_char == 8'd0))
  `GLCQ_ASSERT_IMP(a_count_cap, out_valid, queue_count <= 5'(QUEUE_SLOTS))
  `GLCQ_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid)

endmodule

bind gcode_line_checker_queue_core glcq_checker #(.QUEUE_SLOTS(QUEUE_SLOTS)) u_glcq_checker (
  .clk(clk),
  .rst(rst),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .result_kind(result_kind),
  .status(status),
  .resend_request(resend_request),
  .line_length(line_length),
  .slot_written(slot_written),
  .emergency_code(emergency_code),
  .read_char(read_char),
  .queue_count(queue_count)
);
